// ----- sv/cbm_pkg.sv -----
// Package for the cartridge bank mapper: event kinds, handled codes, register addresses,
// config indices, sequencer states and the structs passed between sequencer and divider.
`default_nettype none
package cbm_pkg;
    typedef enum logic [2:0] {
        KIND_CPU_RD  = 3'd0,
        KIND_CPU_WR  = 3'd1,
        KIND_PPU_RD  = 3'd2,
        KIND_PPU_WR  = 3'd3,
        KIND_LINE    = 3'd4,
        KIND_IRQ_ACK = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        HND_NONE = 2'd0,
        HND_ADDR = 2'd1,
        HND_DATA = 2'd2
    } handled_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RAMRD,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

    localparam logic [15:0] REG_AUDIO    = 16'h5015;
    localparam logic [15:0] REG_PRG_MODE = 16'h5100;
    localparam logic [15:0] REG_CHR_MODE = 16'h5101;
    localparam logic [15:0] REG_EXRAM_MD = 16'h5104;
    localparam logic [15:0] REG_CHR_UP   = 16'h5130;
    localparam logic [15:0] REG_IRQ_LINE = 16'h5203;
    localparam logic [15:0] REG_IRQ_STAT = 16'h5204;
    localparam logic [15:0] REG_MUL_A    = 16'h5205;
    localparam logic [15:0] REG_MUL_B    = 16'h5206;

    localparam int BANK_BITS = 11;

    typedef struct packed {
        logic                 start;
        logic [BANK_BITS-1:0] dividend;
        logic [BANK_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [BANK_BITS-1:0] remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- sv/cbm_if.sv -----
// Valid/ready channel interfaces for bus events and results.
// Depends on nothing.
`default_nettype none
interface cbm_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        bg_fetch;
    logic [5:0]  ext_chr_page;
    logic signed [9:0] line;
    modport source (output valid, kind, address, write_data, bg_fetch, ext_chr_page, line,
                    input ready);
    modport sink (input valid, kind, address, write_data, bg_fetch, ext_chr_page, line,
                  output ready);
endinterface

interface cbm_result_if #(parameter int MAPPED_ADDR_BITS = 20);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  handled;
    logic [MAPPED_ADDR_BITS-1:0] mapped_address;
    logic [7:0]                  read_data;
    logic                        irq_pending;
    modport source (output valid, handled, mapped_address, read_data, irq_pending,
                    input ready);
    modport sink (input valid, handled, mapped_address, read_data, irq_pending,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/cbm_divider.sv -----
// Restoring bit-serial remainder unit, one quotient bit per cycle.
// Depends on cbm_pkg.
`default_nettype none
module cbm_divider
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cbm_pkg::div_req_t req,
    output cbm_pkg::div_rsp_t  rsp
);
    localparam int N = cbm_pkg::BANK_BITS;

    logic [N-1:0]         rem_reg, rem_next;
    logic [N-1:0]         dvd_reg, dvd_next;
    logic [N-1:0]         dvs_reg, dvs_next;
    logic [$clog2(N):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [N:0]           trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[N-1]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = ($clog2(N)+1)'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[N])
                rem_next = {rem_reg[N-2:0], dvd_reg[N-1]};
            else
                rem_next = trial[N-1:0];
            dvd_next = {dvd_reg[N-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ($clog2(N)+1)'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

// ----- sv/cartridge_bank_mapper_irq.sv -----
// Cartridge bank mapper with scanline interrupt: one bus event in, one result out.
// Uses cbm_pkg, cbm_if and cbm_divider.
// Writes, ticks, acks, register reads and unbanked pattern accesses pass through the
// execute, RAM read and output states; banked reads also wait in the divide state for
// the 11-step bank remainder in cbm_divider. After reset a pass clears every extended
// RAM entry before the first event is accepted.
`default_nettype none
module cartridge_bank_mapper_irq #(
    parameter int EXRAM_DEPTH      = 1024,
    parameter int MAPPED_ADDR_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cbm_event_if.sink        evt,
    cbm_result_if.source     res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    localparam int EA = $clog2(EXRAM_DEPTH);
    localparam int NB = cbm_pkg::BANK_BITS;

    logic [7:0]  prg_cnt_reg;
    logic [10:0] chr_cnt_reg;
    logic        chr_ram_reg;

    logic [1:0]  prg_mode_reg, chr_mode_reg, exram_mode_reg, chr_upper_reg, audio_reg;
    logic [7:0]  prg_banks_reg [4];
    logic [7:0]  spr_banks_reg [8];
    logic [7:0]  bg_banks_reg  [4];
    logic [7:0]  fa_reg, fb_reg, cmp_reg, stat_reg;
    logic [15:0] prod_reg;
    logic        irq_en_reg, irq_flag_reg;

    logic [7:0]  exram [EXRAM_DEPTH];
    logic [7:0]  exram_q_reg;
    logic [EA:0] clr_reg;

    cbm_pkg::state_t state_reg, state_next;
    logic [2:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wd_reg;
    logic        bg_reg;
    logic [5:0]  page_reg;
    logic signed [9:0] line_reg;

    logic [1:0]  hnd_reg;
    logic [MAPPED_ADDR_BITS-1:0] map_reg;
    logic [7:0]  rd_reg;
    logic [NB-1:0] bank_reg;
    logic [12:0] off_reg;
    logic        is_chr_reg;

    cbm_pkg::div_req_t dreq;
    cbm_pkg::div_rsp_t drsp;

    cbm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic clearing;
    assign clearing  = !clr_reg[EA];
    assign evt.ready = (state_reg == cbm_pkg::ST_IDLE) && !clearing;
    assign res.valid = (state_reg == cbm_pkg::ST_OUT);
    assign res.handled        = hnd_reg;
    assign res.mapped_address = map_reg;
    assign res.read_data      = rd_reg;
    assign res.irq_pending    = irq_flag_reg;

    logic        ppu_bg;
    logic [2:0]  slot;
    logic [1:0]  bslot;
    logic [9:0]  chr_bank;
    logic [6:0]  prg_bank;
    logic [14:0] prg_off;
    logic        is_ext;
    logic [15:0] a14;
    logic signed [9:0] cmp_s;

    always_comb
    begin
        a14      = {2'b00, addr_reg[13:0]};
        slot     = addr_reg[12:10];
        bslot    = addr_reg[11:10];
        ppu_bg   = bg_reg;
        chr_bank = '0;
        if (ppu_bg && exram_mode_reg == 2'd1)
            chr_bank = {2'b00, page_reg, bslot};
        else
        begin
            case (chr_mode_reg)
                2'd0:
                    chr_bank = ppu_bg ? {chr_upper_reg, bg_banks_reg[3] & 8'hFC} + 10'(bslot)
                                      : {chr_upper_reg, spr_banks_reg[7] & 8'hF8} + 10'(slot);
                2'd1:
                    chr_bank = ppu_bg ? {chr_upper_reg, bg_banks_reg[3] & 8'hFC} + 10'(bslot)
                                      : {chr_upper_reg,
                                         spr_banks_reg[slot[2] ? 3'd7 : 3'd3] & 8'hFC}
                                        + 10'(slot[1:0]);
                2'd2:
                    chr_bank = ppu_bg
                        ? {chr_upper_reg, bg_banks_reg[{bslot[1], 1'b1}] & 8'hFE}
                          + 10'(bslot[0])
                        : {chr_upper_reg, spr_banks_reg[{slot[2:1], 1'b1}] & 8'hFE}
                          + 10'(slot[0]);
                default:
                    chr_bank = {chr_upper_reg, ppu_bg ? bg_banks_reg[bslot] : spr_banks_reg[slot]};
            endcase
        end
        prg_bank = '0;
        prg_off  = '0;
        case (prg_mode_reg)
            2'd0:
            begin
                prg_bank = prg_banks_reg[3][6:0] & 7'h7C;
                prg_off  = addr_reg[14:0];
            end
            2'd1:
            begin
                prg_bank = (addr_reg[14] ? prg_banks_reg[3][6:0] : prg_banks_reg[1][6:0]) & 7'h7E;
                prg_off  = {1'b0, addr_reg[13:0]};
            end
            2'd2:
            begin
                if (!addr_reg[14])
                begin
                    prg_bank = prg_banks_reg[1][6:0] & 7'h7E;
                    prg_off  = {1'b0, addr_reg[13:0]};
                end
                else
                begin
                    prg_bank = addr_reg[13] ? prg_banks_reg[3][6:0] : prg_banks_reg[2][6:0];
                    prg_off  = {2'b00, addr_reg[12:0]};
                end
            end
            default:
            begin
                prg_bank = prg_banks_reg[addr_reg[14:13]][6:0];
                prg_off  = {2'b00, addr_reg[12:0]};
            end
        endcase
        is_ext = addr_reg >= 16'h5C00 && addr_reg <= 16'h5FFF;
        cmp_s  = $signed({2'b00, cmp_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        dreq.start     = 1'b0;
        dreq.dividend  = '0;
        dreq.divisor   = '0;
        if (is_chr_reg)
        begin
            dreq.dividend = bank_reg;
            dreq.divisor  = (chr_cnt_reg == '0) ? NB'(1) : chr_cnt_reg;
        end
        else
        begin
            dreq.dividend = bank_reg;
            dreq.divisor  = (prg_cnt_reg == '0) ? NB'(1) : NB'(prg_cnt_reg);
        end
        case (state_reg)
            cbm_pkg::ST_IDLE:
                if (evt.valid && evt.ready)
                    state_next = cbm_pkg::ST_EXEC;
            cbm_pkg::ST_EXEC:
                state_next = cbm_pkg::ST_RAMRD;
            cbm_pkg::ST_RAMRD:
                if (hnd_reg == cbm_pkg::HND_ADDR && bank_reg != '1)
                begin
                    dreq.start = 1'b1;
                    state_next = cbm_pkg::ST_DIV;
                end
                else
                    state_next = cbm_pkg::ST_OUT;
            cbm_pkg::ST_DIV:
                if (drsp.done)
                    state_next = cbm_pkg::ST_OUT;
            cbm_pkg::ST_OUT:
                if (res.ready)
                    state_next = cbm_pkg::ST_IDLE;
            default:
                state_next = cbm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cbm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            kind_reg <= evt.kind;
            addr_reg <= evt.address;
            wd_reg   <= evt.write_data;
            bg_reg   <= evt.bg_fetch;
            page_reg <= evt.ext_chr_page;
            line_reg <= evt.line;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            exram[clr_reg[EA-1:0]] <= '0;
        else if (state_reg == cbm_pkg::ST_EXEC && kind_reg == cbm_pkg::KIND_CPU_WR && is_ext)
            exram[addr_reg[EA-1:0]] <= wd_reg;
        exram_q_reg <= exram[addr_reg[EA-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            prg_cnt_reg    <= 8'd2;
            chr_cnt_reg    <= 11'd8;
            chr_ram_reg    <= 1'b0;
            prg_mode_reg   <= 2'd3;
            chr_mode_reg   <= 2'd3;
            exram_mode_reg <= '0;
            chr_upper_reg  <= '0;
            audio_reg      <= '0;
            prg_banks_reg[0] <= 8'd0;
            prg_banks_reg[1] <= 8'd1;
            prg_banks_reg[2] <= 8'd0;
            prg_banks_reg[3] <= 8'd1;
            for (int i = 0; i < 8; i++)
                spr_banks_reg[i] <= 8'(i);
            for (int i = 0; i < 4; i++)
                bg_banks_reg[i] <= 8'(i);
            fa_reg       <= '0;
            fb_reg       <= '0;
            prod_reg     <= '0;
            cmp_reg      <= '0;
            stat_reg     <= '0;
            irq_en_reg   <= 1'b0;
            irq_flag_reg <= 1'b0;
            hnd_reg      <= cbm_pkg::HND_NONE;
            map_reg      <= '0;
            rd_reg       <= '0;
            bank_reg     <= '0;
            off_reg      <= '0;
            is_chr_reg   <= 1'b0;
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    cbm_pkg::CFG_PRG_COUNT: prg_cnt_reg <= cfg_data[7:0];
                    cbm_pkg::CFG_CHR_COUNT: chr_cnt_reg <= cfg_data;
                    cbm_pkg::CFG_CHR_RAM:   chr_ram_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                cbm_pkg::ST_EXEC:
                begin
                    hnd_reg    <= cbm_pkg::HND_NONE;
                    map_reg    <= '0;
                    rd_reg     <= '0;
                    bank_reg   <= '1;
                    is_chr_reg <= 1'b0;
                    case (kind_reg)
                        cbm_pkg::KIND_CPU_RD:
                        begin
                            if (is_ext)
                                hnd_reg <= cbm_pkg::HND_DATA;
                            else if (addr_reg == cbm_pkg::REG_AUDIO)
                            begin
                                hnd_reg <= cbm_pkg::HND_DATA;
                                rd_reg  <= {6'd0, audio_reg};
                            end
                            else if (addr_reg == cbm_pkg::REG_IRQ_STAT)
                            begin
                                hnd_reg      <= cbm_pkg::HND_DATA;
                                rd_reg       <= stat_reg;
                                stat_reg[7]  <= 1'b0;
                                irq_flag_reg <= 1'b0;
                            end
                            else if (addr_reg == cbm_pkg::REG_MUL_A)
                            begin
                                hnd_reg <= cbm_pkg::HND_DATA;
                                rd_reg  <= prod_reg[7:0];
                            end
                            else if (addr_reg == cbm_pkg::REG_MUL_B)
                            begin
                                hnd_reg <= cbm_pkg::HND_DATA;
                                rd_reg  <= prod_reg[15:8];
                            end
                            else if (addr_reg[15])
                            begin
                                hnd_reg  <= cbm_pkg::HND_ADDR;
                                bank_reg <= NB'(prg_bank);
                                off_reg  <= prg_off[12:0];
                                map_reg  <= MAPPED_ADDR_BITS'({prg_off[14:13], 13'd0});
                            end
                        end
                        cbm_pkg::KIND_CPU_WR:
                        begin
                            if (addr_reg >= 16'h5114 && addr_reg <= 16'h5117)
                                prg_banks_reg[addr_reg[1:0]] <= wd_reg;
                            else if (addr_reg >= 16'h5120 && addr_reg <= 16'h5127)
                                spr_banks_reg[addr_reg[2:0]] <= wd_reg;
                            else if (addr_reg >= 16'h5128 && addr_reg <= 16'h512B)
                                bg_banks_reg[addr_reg[1:0]] <= wd_reg;
                            case (addr_reg)
                                cbm_pkg::REG_AUDIO:    audio_reg      <= wd_reg[1:0];
                                cbm_pkg::REG_PRG_MODE: prg_mode_reg   <= wd_reg[1:0];
                                cbm_pkg::REG_CHR_MODE: chr_mode_reg   <= wd_reg[1:0];
                                cbm_pkg::REG_EXRAM_MD: exram_mode_reg <= wd_reg[1:0];
                                cbm_pkg::REG_CHR_UP:   chr_upper_reg  <= wd_reg[1:0];
                                cbm_pkg::REG_IRQ_LINE: cmp_reg        <= wd_reg;
                                cbm_pkg::REG_IRQ_STAT:
                                begin
                                    irq_en_reg   <= wd_reg[7];
                                    stat_reg[7]  <= 1'b0;
                                    irq_flag_reg <= 1'b0;
                                end
                                cbm_pkg::REG_MUL_A:
                                begin
                                    fa_reg   <= wd_reg;
                                    prod_reg <= wd_reg * fb_reg;
                                end
                                cbm_pkg::REG_MUL_B:
                                begin
                                    fb_reg   <= wd_reg;
                                    prod_reg <= fa_reg * wd_reg;
                                end
                                default: ;
                            endcase
                        end
                        cbm_pkg::KIND_PPU_RD:
                        begin
                            if (!addr_reg[13])
                            begin
                                hnd_reg <= cbm_pkg::HND_ADDR;
                                if (chr_ram_reg)
                                    map_reg <= MAPPED_ADDR_BITS'(a14);
                                else
                                begin
                                    bank_reg   <= NB'(chr_bank);
                                    is_chr_reg <= 1'b1;
                                    off_reg    <= {3'd0, addr_reg[9:0]};
                                end
                            end
                        end
                        cbm_pkg::KIND_PPU_WR:
                        begin
                            if (!addr_reg[13] && chr_ram_reg)
                            begin
                                hnd_reg <= cbm_pkg::HND_ADDR;
                                map_reg <= MAPPED_ADDR_BITS'(a14);
                            end
                        end
                        cbm_pkg::KIND_LINE:
                        begin
                            stat_reg[6] <= (line_reg >= 10'sd0) && (line_reg < 10'sd240);
                            if (irq_en_reg && line_reg == cmp_s)
                            begin
                                stat_reg[7]  <= 1'b1;
                                irq_flag_reg <= 1'b1;
                            end
                        end
                        cbm_pkg::KIND_IRQ_ACK:
                        begin
                            stat_reg[7]  <= 1'b0;
                            irq_flag_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                cbm_pkg::ST_RAMRD:
                    if (hnd_reg == cbm_pkg::HND_DATA && kind_reg == cbm_pkg::KIND_CPU_RD && is_ext)
                        rd_reg <= exram_q_reg;
                cbm_pkg::ST_DIV:
                    if (drsp.done)
                    begin
                        if (is_chr_reg)
                            map_reg <= MAPPED_ADDR_BITS'({drsp.remainder, 10'd0})
                                       + MAPPED_ADDR_BITS'(off_reg);
                        else
                            map_reg <= map_reg + MAPPED_ADDR_BITS'({drsp.remainder, 13'd0})
                                       + MAPPED_ADDR_BITS'(off_reg);
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/cbm_checker.sv -----
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg.
`default_nettype none
module cbm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] handled,
    input wire logic [7:0] read_data
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after accept");
    a_handled_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> handled != 2'd3)
        else $error("bad handled code");
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && handled != cbm_pkg::HND_DATA) |-> read_data == 8'd0)
        else $error("read data without register read");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(handled))
        else $error("result dropped");
endmodule

bind cartridge_bank_mapper_irq cbm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(evt.valid), .in_ready(evt.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .handled(res.handled), .read_data(res.read_data)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking bench for the cartridge bank mapper: random and directed bus events,
// result prediction in a scoreboard class. Depends on cbm_pkg, cbm_if and the RTL.
`default_nettype none
module tb_top;
    typedef struct {
        logic [1:0]  handled;
        logic [19:0] mapped;
        logic [7:0]  rdata;
        logic        irq;
    } map_result_t;

    class mapper_scoreboard;
        int unsigned prg_cnt, chr_cnt;
        bit chr_ram;
        bit [1:0] prg_mode, chr_mode, exram_mode, chr_upper, audio;
        bit [7:0] prg_banks[4];
        bit [7:0] spr_banks[8];
        bit [7:0] bg_banks[4];
        bit [7:0] exram[1024];
        bit [7:0] fa, fb, irq_line, irq_stat;
        bit [15:0] prod;
        bit irq_en, irq_flag;
        map_result_t pending[$];
        int errors;

        function new();
            prg_cnt = 2; chr_cnt = 8; chr_ram = 0;
            prg_mode = 3; chr_mode = 3; exram_mode = 0; chr_upper = 0; audio = 0;
            prg_banks = '{0, 1, 0, 1};
            for (int i = 0; i < 8; i++) spr_banks[i] = 8'(i);
            for (int i = 0; i < 4; i++) bg_banks[i] = 8'(i);
            foreach (exram[i]) exram[i] = 0;
            fa = 0; fb = 0; prod = 0; irq_line = 0; irq_stat = 0;
            irq_en = 0; irq_flag = 0; errors = 0;
        endfunction

        function void set_reg(int idx, int val);
            if (idx == cbm_pkg::CFG_PRG_COUNT) prg_cnt = val & 8'hFF;
            else if (idx == cbm_pkg::CFG_CHR_COUNT) chr_cnt = val & 11'h7FF;
            else chr_ram = 1'(val & 1);
        endfunction

        function bit [19:0] prg_addr(int unsigned bank, int unsigned ofs);
            int unsigned n;
            n = (prg_cnt == 0) ? 1 : prg_cnt;
            return 20'((bank % n) * 32'h2000 + ofs);
        endfunction

        function bit [19:0] chr_addr(int unsigned bank, int unsigned a);
            int unsigned n;
            n = (chr_cnt == 0) ? 1 : chr_cnt;
            return 20'((bank % n) * 32'h400 + (a & 32'h3FF));
        endfunction

        function bit [19:0] cpu_map(int unsigned a);
            int unsigned b1, b2, b3;
            b1 = prg_banks[1] & 8'h7F; b2 = prg_banks[2] & 8'h7F; b3 = prg_banks[3] & 8'h7F;
            case (prg_mode)
                0: return prg_addr(b3 & 8'h7C, a & 16'h7FFF);
                1: return (a < 16'hC000) ? prg_addr(b1 & 8'h7E, a & 16'h3FFF)
                                         : prg_addr(b3 & 8'h7E, a & 16'h3FFF);
                2:
                begin
                    if (a < 16'hC000) return prg_addr(b1 & 8'h7E, a & 16'h3FFF);
                    if (a < 16'hE000) return prg_addr(b2, a & 16'h1FFF);
                    return prg_addr(b3, a & 16'h1FFF);
                end
                default:
                begin
                    if (a < 16'hA000) return prg_addr(prg_banks[0] & 8'h7F, a & 16'h1FFF);
                    if (a < 16'hC000) return prg_addr(b1, a & 16'h1FFF);
                    if (a < 16'hE000) return prg_addr(b2, a & 16'h1FFF);
                    return prg_addr(b3, a & 16'h1FFF);
                end
            endcase
        endfunction

        function bit [19:0] ppu_map(int unsigned a, bit bg, int unsigned page);
            int unsigned up, slot, bslot, bank;
            up = chr_upper << 8; slot = (a >> 10) & 7; bslot = (a >> 10) & 3;
            if (bg && exram_mode == 1) return chr_addr((page << 2) + bslot, a);
            case (chr_mode)
                0: bank = bg ? (up | (bg_banks[3] & 8'hFC)) + bslot
                             : (up | (spr_banks[7] & 8'hF8)) + slot;
                1: bank = bg ? (up | (bg_banks[3] & 8'hFC)) + bslot
                             : (up | (spr_banks[slot < 4 ? 3 : 7] & 8'hFC)) + (slot & 3);
                2: bank = bg ? (up | (bg_banks[(bslot >> 1) * 2 + 1] & 8'hFE)) + (bslot & 1)
                             : (up | (spr_banks[(slot >> 1) * 2 + 1] & 8'hFE)) + (slot & 1);
                default: bank = up | (bg ? bg_banks[bslot] : spr_banks[slot]);
            endcase
            return chr_addr(bank, a);
        endfunction

        function void note_event(bit [2:0] kind, bit [15:0] a, bit [7:0] d, bit bg,
                                 bit [5:0] page, bit signed [9:0] ln);
            map_result_t r;
            int unsigned pa;
            r = '{cbm_pkg::HND_NONE, 0, 0, 0};
            case (kind)
                cbm_pkg::KIND_CPU_RD:
                begin
                    if (a >= 16'h5C00 && a <= 16'h5FFF)
                    begin
                        r.rdata = exram[a[9:0]]; r.handled = cbm_pkg::HND_DATA;
                    end
                    else if (a == cbm_pkg::REG_AUDIO)
                    begin
                        r.rdata = {6'd0, audio}; r.handled = cbm_pkg::HND_DATA;
                    end
                    else if (a == cbm_pkg::REG_IRQ_STAT)
                    begin
                        r.rdata = irq_stat; r.handled = cbm_pkg::HND_DATA;
                        irq_stat[7] = 0; irq_flag = 0;
                    end
                    else if (a == cbm_pkg::REG_MUL_A)
                    begin
                        r.rdata = prod[7:0]; r.handled = cbm_pkg::HND_DATA;
                    end
                    else if (a == cbm_pkg::REG_MUL_B)
                    begin
                        r.rdata = prod[15:8]; r.handled = cbm_pkg::HND_DATA;
                    end
                    else if (a >= 16'h8000)
                    begin
                        r.handled = cbm_pkg::HND_ADDR; r.mapped = cpu_map(a);
                    end
                end
                cbm_pkg::KIND_CPU_WR:
                begin
                    if (a >= 16'h5114 && a <= 16'h5117) prg_banks[a[1:0]] = d;
                    else if (a >= 16'h5120 && a <= 16'h5127) spr_banks[a[2:0]] = d;
                    else if (a >= 16'h5128 && a <= 16'h512B) bg_banks[a[1:0]] = d;
                    else if (a >= 16'h5C00 && a <= 16'h5FFF) exram[a[9:0]] = d;
                    else if (a == cbm_pkg::REG_AUDIO) audio = d[1:0];
                    else if (a == cbm_pkg::REG_PRG_MODE) prg_mode = d[1:0];
                    else if (a == cbm_pkg::REG_CHR_MODE) chr_mode = d[1:0];
                    else if (a == cbm_pkg::REG_EXRAM_MD) exram_mode = d[1:0];
                    else if (a == cbm_pkg::REG_CHR_UP) chr_upper = d[1:0];
                    else if (a == cbm_pkg::REG_IRQ_LINE) irq_line = d;
                    else if (a == cbm_pkg::REG_IRQ_STAT)
                    begin
                        irq_en = d[7]; irq_stat[7] = 0; irq_flag = 0;
                    end
                    else if (a == cbm_pkg::REG_MUL_A)
                    begin
                        fa = d; prod = fa * fb;
                    end
                    else if (a == cbm_pkg::REG_MUL_B)
                    begin
                        fb = d; prod = fa * fb;
                    end
                end
                cbm_pkg::KIND_PPU_RD:
                begin
                    pa = a & 16'h3FFF;
                    if (pa < 16'h2000)
                    begin
                        r.handled = cbm_pkg::HND_ADDR;
                        r.mapped = chr_ram ? 20'(pa) : ppu_map(pa, bg, page);
                    end
                end
                cbm_pkg::KIND_PPU_WR:
                begin
                    pa = a & 16'h3FFF;
                    if (pa < 16'h2000 && chr_ram)
                    begin
                        r.handled = cbm_pkg::HND_ADDR; r.mapped = 20'(pa);
                    end
                end
                cbm_pkg::KIND_LINE:
                begin
                    irq_stat[6] = (ln >= 10'sd0 && ln < 10'sd240);
                    if (irq_en && int'(ln) == int'(irq_line))
                    begin
                        irq_stat[7] = 1; irq_flag = 1;
                    end
                end
                cbm_pkg::KIND_IRQ_ACK:
                begin
                    irq_flag = 0; irq_stat[7] = 0;
                end
                default: ;
            endcase
            r.irq = irq_flag;
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] h, logic [19:0] m, logic [7:0] rd, logic irq);
            map_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result h=%0d m=%h", h, m);
                return;
            end
            e = pending.pop_front();
            if (h !== e.handled || m !== e.mapped || rd !== e.rdata || irq !== e.irq)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp h=%0d m=%h d=%h i=%b got h=%0d m=%h d=%h i=%b",
                             e.handled, e.mapped, e.rdata, e.irq, h, m, rd, irq);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = 0;
    logic [10:0] cfg_data = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    mapper_scoreboard sb;

    cbm_event_if evt();
    cbm_result_if #(.MAPPED_ADDR_BITS(20)) res();

    cartridge_bank_mapper_irq dut (
        .clk(clk), .rst_n(rst_n), .evt(evt.sink), .res(res.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        evt.valid = 0; evt.kind = 0; evt.address = 0; evt.write_data = 0;
        evt.bg_fetch = 0; evt.ext_chr_page = 0; evt.line = 0;
        res.ready = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt.valid && evt.ready)
                sb.note_event(evt.kind, evt.address, evt.write_data, evt.bg_fetch,
                              evt.ext_chr_page, evt.line);
            if (res.valid && res.ready)
                sb.check_result(res.handled, res.mapped_address, res.read_data,
                                res.irq_pending);
            if ((evt.valid && evt.ready) || (res.valid && res.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000 && !timed_out)
            begin
                timed_out = 1;
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern: alternating busy and free stretches
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(0, 3);
            repeat ($urandom_range(1, 20)) @(posedge clk) res.ready <= (n == 0) ? 1'b1 :
                ($urandom_range(0, n) == 0 ? 1'b0 : 1'b1);
            repeat ($urandom_range(0, 4)) @(posedge clk) res.ready <= 1'b0;
        end
    end

    int burst_left = 0;

    task automatic send_event(bit [2:0] k, bit [15:0] a, bit [7:0] d, bit bg,
                              bit [5:0] page, bit signed [9:0] ln);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                evt.valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        evt.valid <= 1; evt.kind <= k; evt.address <= a; evt.write_data <= d;
        evt.bg_fetch <= bg; evt.ext_chr_page <= page; evt.line <= ln;
        do @(posedge clk); while (!evt.ready);
        burst_left--;
    endtask

    task automatic write_cfg(bit [1:0] idx, int val);
        evt.valid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= 11'(val);
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic cpu_wr(bit [15:0] a, bit [7:0] d);
        send_event(cbm_pkg::KIND_CPU_WR, a, d, 0, 0, 0);
    endtask

    function automatic bit [15:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 16'(16'h5100 + $urandom_range(0, 4));
            1: return 16'(16'h5114 + $urandom_range(0, 3));
            2: return 16'(16'h5120 + $urandom_range(0, 16));
            3: return 16'(16'h5C00 + $urandom_range(0, 1023));
            4:
            begin
                case ($urandom_range(0, 5))
                    0: return cbm_pkg::REG_AUDIO;
                    1: return cbm_pkg::REG_CHR_UP;
                    2: return cbm_pkg::REG_IRQ_LINE;
                    3: return cbm_pkg::REG_IRQ_STAT;
                    4: return cbm_pkg::REG_MUL_A;
                    default: return cbm_pkg::REG_MUL_B;
                endcase
            end
            5, 6: return 16'(16'h8000 + $urandom_range(0, 16'h7FFF));
            7: return 16'($urandom_range(0, 16'h3FFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic random_events(int n);
        bit [2:0] k;
        bit [15:0] a;
        for (int i = 0; i < n; i++)
        begin
            k = 3'($urandom_range(0, 7));
            if (k > 5 && $urandom_range(0, 3) != 0) k = 3'($urandom_range(0, 2));
            a = pick_addr();
            if ((k == cbm_pkg::KIND_PPU_RD || k == cbm_pkg::KIND_PPU_WR) &&
                $urandom_range(0, 3) != 0)
                a = 16'($urandom_range(0, 16'h1FFF) | ($urandom_range(0, 3) << 14));
            if (k == cbm_pkg::KIND_CPU_WR && (a == cbm_pkg::REG_PRG_MODE ||
                a == cbm_pkg::REG_CHR_MODE || a == cbm_pkg::REG_EXRAM_MD) &&
                $urandom_range(0, 1))
                a = 16'(16'h5114 + $urandom_range(0, 23));
            send_event(k, a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       6'($urandom_range(0, 63)), 10'($urandom_range(0, 263)) - 10'sd1);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        // directed part
        send_event(cbm_pkg::KIND_CPU_RD, 16'h5C00, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_CPU_RD, 16'hFFFF, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_CPU_RD, 16'h6000, 0, 0, 0, 0);
        cpu_wr(16'h5FFF, 8'hFF);
        send_event(cbm_pkg::KIND_CPU_RD, 16'h5FFF, 0, 0, 0, 0);
        cpu_wr(cbm_pkg::REG_MUL_A, 8'hFF);
        cpu_wr(cbm_pkg::REG_MUL_B, 8'hFF);
        send_event(cbm_pkg::KIND_CPU_RD, cbm_pkg::REG_MUL_A, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_CPU_RD, cbm_pkg::REG_MUL_B, 0, 0, 0, 0);
        cpu_wr(cbm_pkg::REG_IRQ_LINE, 8'd0);
        cpu_wr(cbm_pkg::REG_IRQ_STAT, 8'h80);
        send_event(cbm_pkg::KIND_LINE, 0, 0, 0, 0, 10'sd0);
        send_event(cbm_pkg::KIND_CPU_RD, cbm_pkg::REG_IRQ_STAT, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_LINE, 0, 0, 0, 0, -10'sd1);
        send_event(cbm_pkg::KIND_LINE, 0, 0, 0, 0, 10'sd0);
        send_event(cbm_pkg::KIND_IRQ_ACK, 0, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_PPU_RD, 16'h1FFF, 0, 1, 6'h3F, 0);
        send_event(cbm_pkg::KIND_PPU_RD, 16'hE000, 0, 0, 0, 0);
        send_event(cbm_pkg::KIND_PPU_WR, 16'h0400, 0, 0, 0, 0);
        send_event(3'd6, 16'hFFFF, 8'hFF, 1, 6'h3F, 10'sd261);
        send_event(3'd7, 0, 0, 0, 0, 0);
        cpu_wr(16'h5117, 8'hFF);
        send_event(cbm_pkg::KIND_CPU_RD, 16'hE000, 0, 0, 0, 0);
        // phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(cbm_pkg::CFG_PRG_COUNT, 0);
                    write_cfg(cbm_pkg::CFG_CHR_COUNT, 0);
                    write_cfg(cbm_pkg::CFG_CHR_RAM, 1);
                end
                1:
                begin
                    write_cfg(cbm_pkg::CFG_PRG_COUNT, 255);
                    write_cfg(cbm_pkg::CFG_CHR_COUNT, 2047);
                    write_cfg(cbm_pkg::CFG_CHR_RAM, 0);
                end
                2:
                begin
                    write_cfg(cbm_pkg::CFG_PRG_COUNT, 1);
                    write_cfg(cbm_pkg::CFG_CHR_COUNT, 8);
                end
                3:
                begin
                    write_cfg(cbm_pkg::CFG_PRG_COUNT, 128);
                    write_cfg(cbm_pkg::CFG_CHR_COUNT, 1024);
                end
                default:
                begin
                    write_cfg(cbm_pkg::CFG_PRG_COUNT, $urandom_range(1, 128));
                    write_cfg(cbm_pkg::CFG_CHR_COUNT, $urandom_range(8, 1024));
                    write_cfg(cbm_pkg::CFG_CHR_RAM, $urandom_range(0, 1));
                end
            endcase
            random_events(72);
        end
        evt.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/cbm_pkg.sv
sv/cbm_if.sv
sv/cbm_divider.sv
sv/cartridge_bank_mapper_irq.sv
sv/cbm_checker.sv
dv/tb_top.sv
